/* src/lfd_pkg.sv */
// shared types, constants and decode tables for the lpcm disc frame decoder
// no dependencies
`timescale 1ns / 1ps

package lfd_pkg;

   localparam int MAX_SLOTS       = 8;
   localparam int SLOT_BITS       = $clog2(MAX_SLOTS);
   localparam int BYTE_COUNT_BITS = 16;
   localparam int USED_BITS       = 16;

   typedef logic [BYTE_COUNT_BITS-1:0] bcnt_type;
   typedef logic [SLOT_BITS-1:0]       slot_type;

   // layout codes that need a channel remap
   localparam logic [3:0] LAYOUT_5_1 = 4'd9;
   localparam logic [3:0] LAYOUT_7_0 = 4'd10;
   localparam logic [3:0] LAYOUT_7_1 = 4'd11;

   // rate codes
   localparam logic [3:0] RATE_CODE_48K  = 4'd1;
   localparam logic [3:0] RATE_CODE_96K  = 4'd4;
   localparam logic [3:0] RATE_CODE_192K = 4'd5;

   localparam logic [4:0] DEPTH_16 = 5'd16;
   localparam logic [4:0] DEPTH_24 = 5'd24;

   typedef enum logic [1:0] {
      KIND_SAMPLE  = 2'd0,
      KIND_INFO    = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_DEPTH   = 3'd1,
      ST_RSV_RATE    = 3'd2,
      ST_RSV_LAYOUT  = 3'd3,
      ST_SHORT       = 3'd4
   } status_type;

   // frame buffer write port
   typedef struct packed {
      logic            en;
      slot_type        addr;
      logic [31:0]     data;
   } slot_wr_type;

   // one result word
   typedef struct packed {
      kind_type                kind;
      logic signed [31:0]      sample_value;
      logic [2:0]              output_slot;
      logic                    frame_last;
      logic [17:0]             sample_rate_hz;
      logic [3:0]              channel_count;
      logic [4:0]              sample_bits;
      logic [25:0]             stream_rate;
      status_type              status;
      logic [USED_BITS-1:0]    bytes_used;
      logic                    last;
   } rsp_type;

   function automatic logic [4:0] depth_of(input logic [1:0] code);
      logic [4:0] d;
      case (code)
         2'd0: d = 5'd0;
         2'd1: d = 5'd16;
         2'd2: d = 5'd20;
         2'd3: d = 5'd24;
         default: d = 5'd0;
      endcase
      return d;
   endfunction

   function automatic logic [17:0] rate_of(input logic [3:0] code);
      logic [17:0] r;
      case (code)
         RATE_CODE_48K:  r = 18'd48000;
         RATE_CODE_96K:  r = 18'd96000;
         RATE_CODE_192K: r = 18'd192000;
         default:        r = 18'd0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] chan_of(input logic [3:0] layout);
      logic [3:0] c;
      case (layout)
         4'd1:  c = 4'd1;
         4'd3:  c = 4'd2;
         4'd4:  c = 4'd3;
         4'd5:  c = 4'd3;
         4'd6:  c = 4'd4;
         4'd7:  c = 4'd4;
         4'd8:  c = 4'd5;
         4'd9:  c = 4'd6;
         4'd10: c = 4'd7;
         4'd11: c = 4'd8;
         default: c = 4'd0;
      endcase
      return c;
   endfunction

   // source channel index to output slot
   function automatic slot_type slot_of(input logic [3:0] layout, input slot_type idx);
      slot_type s;
      s = idx;
      if (layout == LAYOUT_5_1) begin
         case (idx)
            3'd3: s = 3'd4;
            3'd4: s = 3'd5;
            3'd5: s = 3'd3;
            default: s = idx;
         endcase
      end else if (layout == LAYOUT_7_0) begin
         case (idx)
            3'd3: s = 3'd5;
            3'd4: s = 3'd3;
            3'd5: s = 3'd4;
            default: s = idx;
         endcase
      end else if (layout == LAYOUT_7_1) begin
         case (idx)
            3'd3: s = 3'd6;
            3'd6: s = 3'd7;
            3'd7: s = 3'd3;
            default: s = idx;
         endcase
      end
      return s;
   endfunction

endpackage

/* src/lfd_frame_buf.sv */
// one source frame of samples, held by output slot
// depends on lfd_pkg
`timescale 1ns / 1ps

module lfd_frame_buf
   import lfd_pkg::*;
(
   input  logic        clock,
   input  slot_wr_type wr,
   input  slot_type    rd_addr,
   output logic [31:0] rd_data
);

   logic [31:0] mem [MAX_SLOTS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/lpcm_disc_frame_decoder_top.sv */
// lpcm disc frame decoder: one packet byte per word in, header info, samples
// and a packet summary out; depends on lfd_pkg and lfd_frame_buf
// flow: a byte that raises no result leaves the input ready for the next byte;
// the header byte adds the info state, a finished frame of n coded channels
// adds a frame buffer read, then a load of the output register, per slot,
// and packet end adds the summary state; a stalled output holds the sequencer
// and the input; an info or summary word is loaded into the output register
// from its pending state, a sample word after a buffer read and then a load
// reset (synchronous, active high) clears the control state; no clearing pass
`timescale 1ns / 1ps

module lpcm_disc_frame_decoder_top
   import lfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // byte input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_packet_byte,
   input  logic                  req_end_of_packet,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_result_kind,
   output logic signed [31:0]    rsp_sample_value,
   output logic [2:0]            rsp_output_slot,
   output logic                  rsp_frame_last,
   output logic [17:0]           rsp_sample_rate_hz,
   output logic [3:0]            rsp_channel_count,
   output logic [4:0]            rsp_sample_bits,
   output logic [25:0]           rsp_stream_rate,
   output logic [2:0]            rsp_status,
   output logic [USED_BITS-1:0]  rsp_bytes_used,
   output logic                  rsp_last
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INFO,   // header info word pending
      S_FRD,    // frame buffer read issued
      S_FWR,    // read data ready, load sample word
      S_SUM     // packet summary word pending
   } state_type;

   // control
   state_type   state_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;
   logic        pend_sum_ff;
   slot_type    rd_idx_ff;

   // per-packet and header state
   bcnt_type    byte_cnt_ff,  byte_cnt_in;
   logic [7:0]  hdr2_ff,      hdr2_in;
   logic        d24_ff,       d24_in;
   logic [3:0]  layout_ff,    layout_in;
   status_type  hstat_ff,     hstat_in;
   logic [23:0] asm_ff,       asm_in;
   logic [1:0]  bis_ff,       bis_in;
   slot_type    src_ff,       src_in;
   logic [USED_BITS-1:0] used_ff, used_in;

   // pending result payloads
   logic [17:0] info_rate_ff, info_rate_in;
   logic [3:0]  info_ch_ff,   info_ch_in;
   logic [4:0]  info_bits_ff, info_bits_in;
   logic [25:0] info_brate_ff, info_brate_in;
   status_type  sum_stat_ff,  sum_stat_in;
   logic [USED_BITS-1:0] sum_bytes_ff, sum_bytes_in;

   logic        acc;
   logic        out_free;
   logic        rsp_load;
   logic        go_info;
   logic        frame_done;
   slot_wr_type wr;
   logic [31:0] rd_data;

   // header decode
   logic [4:0]  dec_depth;
   logic [17:0] dec_rate;
   logic [3:0]  dec_layout;
   logic [3:0]  dec_ch;
   logic [3:0]  dec_even;
   status_type  dec_status;
   logic [22:0] dec_rate_d;
   logic [25:0] dec_brate;

   // sample path
   logic [3:0]  coded_ch;
   logic [3:0]  src_ch;
   logic [4:0]  fsize;
   logic [1:0]  bps;
   logic [1:0]  bis_nxt;
   logic [23:0] asm_nxt;
   logic [31:0] sample_v;
   logic [3:0]  src_nxt;
   status_type  st_now;

   assign acc       = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   // output register loads, once the output is free, in any state that has a word pending
   assign rsp_load  = out_free &&
                      (state_ff == S_INFO || state_ff == S_FWR || state_ff == S_SUM);

   // coded and even-rounded source channels of the current layout
   assign coded_ch = chan_of(layout_ff);
   assign src_ch   = (coded_ch + 4'd1) & 4'b1110;
   assign bps      = d24_ff ? 2'd3 : 2'd2;
   // frame size in bytes: source channels times 2 or 3
   assign fsize    = d24_ff ? ({1'b0, src_ch} + {src_ch, 1'b0}) : {src_ch, 1'b0};

   // header fields, valid on the fourth byte
   assign dec_depth  = depth_of(req_packet_byte[7:6]);
   assign dec_rate   = rate_of(hdr2_ff[3:0]);
   assign dec_layout = hdr2_ff[7:4];
   assign dec_ch     = chan_of(dec_layout);
   assign dec_even   = (dec_ch + 4'd1) & 4'b1110;

   always_comb begin
      if (dec_depth != DEPTH_16 && dec_depth != DEPTH_24) begin
         dec_status = ST_BAD_DEPTH;
      end else if (dec_rate == 18'd0) begin
         dec_status = ST_RSV_RATE;
      end else if (dec_ch == 4'd0) begin
         dec_status = ST_RSV_LAYOUT;
      end else begin
         dec_status = ST_OK;
      end
   end

   // rate times depth by shift and add, then one small multiply
   assign dec_rate_d = (dec_depth == DEPTH_24)
                     ? ({1'b0, dec_rate, 4'b0} + {2'b0, dec_rate, 3'b0})
                     : {1'b0, dec_rate, 4'b0};
   assign dec_brate  = {3'b0, dec_rate_d} * {22'b0, dec_even};

   // sample assembly, big-endian
   assign asm_nxt = {asm_ff[15:0], req_packet_byte};
   assign bis_nxt = bis_ff + 2'd1;
   assign src_nxt = {1'b0, src_ff} + 4'd1;
   assign sample_v = d24_ff ? {asm_nxt, 8'h00}
                            : {{16{asm_nxt[15]}}, asm_nxt[15:0]};

   always_comb begin
      byte_cnt_in   = byte_cnt_ff;
      hdr2_in       = hdr2_ff;
      d24_in        = d24_ff;
      layout_in     = layout_ff;
      hstat_in      = hstat_ff;
      asm_in        = asm_ff;
      bis_in        = bis_ff;
      src_in        = src_ff;
      used_in       = used_ff;
      info_rate_in  = info_rate_ff;
      info_ch_in    = info_ch_ff;
      info_bits_in  = info_bits_ff;
      info_brate_in = info_brate_ff;
      sum_stat_in   = sum_stat_ff;
      sum_bytes_in  = sum_bytes_ff;
      go_info       = 1'b0;
      frame_done    = 1'b0;
      wr            = '0;
      st_now        = hstat_ff;

      if (acc) begin
         if (byte_cnt_ff < bcnt_type'(4)) begin
            if (byte_cnt_ff == bcnt_type'(2)) begin
               hdr2_in = req_packet_byte;
            end
            if (byte_cnt_ff == bcnt_type'(3)) begin
               go_info       = 1'b1;
               d24_in        = (dec_depth == DEPTH_24);
               layout_in     = dec_layout;
               hstat_in      = dec_status;
               st_now        = dec_status;
               used_in       = USED_BITS'(4);
               info_rate_in  = dec_rate;
               info_ch_in    = dec_ch;
               info_bits_in  = dec_depth;
               info_brate_in = (dec_status == ST_OK) ? dec_brate : 26'd0;
            end
         end else if (hstat_ff == ST_OK) begin
            // bad header: sample bytes are dropped until packet end
            asm_in = asm_nxt;
            bis_in = bis_nxt;
            if (bis_nxt >= bps) begin
               bis_in = 2'd0;
               if ({1'b0, src_ff} < coded_ch) begin
                  wr.en   = 1'b1;
                  wr.addr = slot_of(layout_ff, src_ff);
                  wr.data = sample_v;
               end
               src_in = src_nxt[SLOT_BITS-1:0];
               if (src_nxt >= src_ch) begin
                  frame_done = 1'b1;
                  src_in     = '0;
                  used_in    = used_ff + USED_BITS'(fsize);
               end
            end
         end

         // saturating byte position
         if (byte_cnt_ff != '1) begin
            byte_cnt_in = byte_cnt_ff + bcnt_type'(1);
         end

         if (req_end_of_packet) begin
            sum_stat_in  = (byte_cnt_ff < bcnt_type'(3)) ? ST_SHORT : st_now;
            sum_bytes_in = (sum_stat_in == ST_OK) ? used_in : '0;
            byte_cnt_in  = '0;
            bis_in       = 2'd0;
            src_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff <= '0;
         d24_ff      <= 1'b0;
         layout_ff   <= 4'd0;
         hstat_ff    <= ST_OK;
         asm_ff      <= 24'd0;
         bis_ff      <= 2'd0;
         src_ff      <= '0;
         used_ff     <= '0;
      end else begin
         byte_cnt_ff <= byte_cnt_in;
         d24_ff      <= d24_in;
         layout_ff   <= layout_in;
         hstat_ff    <= hstat_in;
         asm_ff      <= asm_in;
         bis_ff      <= bis_in;
         src_ff      <= src_in;
         used_ff     <= used_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      hdr2_ff       <= hdr2_in;
      info_rate_ff  <= info_rate_in;
      info_ch_ff    <= info_ch_in;
      info_bits_ff  <= info_bits_in;
      info_brate_ff <= info_brate_in;
      sum_stat_ff   <= sum_stat_in;
      sum_bytes_ff  <= sum_bytes_in;
   end

   // frame buffer: written on the byte that closes a sample, read back slot
   // by slot once the frame is complete
   lfd_frame_buf u_frame_buf (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   // next result word, chosen by the state that is about to load it
   always_comb begin
      rsp_in = '0;
      case (state_ff)
         S_INFO: begin
            rsp_in.kind           = KIND_INFO;
            rsp_in.sample_rate_hz = info_rate_ff;
            rsp_in.channel_count  = info_ch_ff;
            rsp_in.sample_bits    = info_bits_ff;
            rsp_in.stream_rate    = info_brate_ff;
            rsp_in.status         = hstat_ff;
         end
         S_FWR: begin
            rsp_in.kind         = KIND_SAMPLE;
            rsp_in.sample_value = rd_data;
            rsp_in.output_slot  = 3'(rd_idx_ff);
            rsp_in.frame_last   = (({1'b0, rd_idx_ff} + 4'd1) == coded_ch);
         end
         S_SUM: begin
            rsp_in.kind       = KIND_SUMMARY;
            rsp_in.status     = sum_stat_ff;
            rsp_in.bytes_used = sum_bytes_ff;
            rsp_in.last       = 1'b1;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_sum_ff  <= 1'b0;
         rd_idx_ff    <= '0;
      end else begin
         if (rsp_load) begin
            rsp_ff       <= rsp_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (acc) begin
                  pend_sum_ff <= req_end_of_packet;
                  rd_idx_ff   <= '0;
                  if (go_info) begin
                     state_ff <= S_INFO;
                  end else if (frame_done) begin
                     state_ff <= S_FRD;
                  end else if (req_end_of_packet) begin
                     state_ff <= S_SUM;
                  end
               end
            end
            S_INFO: begin
               if (out_free) begin
                  state_ff <= pend_sum_ff ? S_SUM : S_IDLE;
               end
            end
            S_FRD: begin
               state_ff <= S_FWR;
            end
            S_FWR: begin
               if (out_free) begin
                  if (rsp_in.frame_last) begin
                     state_ff <= pend_sum_ff ? S_SUM : S_IDLE;
                  end else begin
                     rd_idx_ff <= rd_idx_ff + slot_type'(1);
                     state_ff  <= S_FRD;
                  end
               end
            end
            S_SUM: begin
               if (out_free) begin
                  pend_sum_ff  <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_ff.kind;
   assign rsp_sample_value   = rsp_ff.sample_value;
   assign rsp_output_slot    = rsp_ff.output_slot;
   assign rsp_frame_last     = rsp_ff.frame_last;
   assign rsp_sample_rate_hz = rsp_ff.sample_rate_hz;
   assign rsp_channel_count  = rsp_ff.channel_count;
   assign rsp_sample_bits    = rsp_ff.sample_bits;
   assign rsp_stream_rate    = rsp_ff.stream_rate;
   assign rsp_status         = rsp_ff.status;
   assign rsp_bytes_used     = rsp_ff.bytes_used;
   assign rsp_last           = rsp_ff.last;

   // frame readback never runs past the coded channels
   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FRD || state_ff == S_FWR) |-> ({1'b0, rd_idx_ff} < coded_ch))
      else $error("frame readback index beyond coded channels");

   // a sample load in the readback state always shows up at the output
   a_sample_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FWR && out_free) |=>
         (rsp_valid_ff && rsp_ff.kind == KIND_SAMPLE))
      else $error("sample word not loaded");

   // only the packet summary closes a packet
   a_last_on_summary: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last) |-> (rsp_ff.kind == KIND_SUMMARY))
      else $error("last flag on a non-summary word");

   // a failed packet reports no consumed bytes
   a_err_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_SUMMARY && rsp_ff.status != ST_OK)
         |-> (rsp_ff.bytes_used == '0))
      else $error("bytes reported on a failed packet");

endmodule
